// ----- rtl/cpds_pkg.sv -----
// shared types and constants for the cyclic prime digit source
`default_nettype none

package cpds_pkg;

    localparam int PRIME_W     = 10;
    localparam int UPPER_LIMIT = 999;
    localparam int DIV_W       = 6;
    localparam int REM_W       = 5;
    localparam int BIT_IDX_W   = $clog2(PRIME_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_OPEN    = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_EOD  = 2'd2;

    localparam logic [1:0] COUNT_NONE   = 2'd0;
    localparam logic [1:0] COUNT_SERVED = 2'd3;

    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_SPACE = 7'h20;

    // what the back end has to do for one beat
    typedef enum logic [1:0] {
        KIND_ACK,
        KIND_BUSY,
        KIND_EOD,
        KIND_SERVE
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV
    } back_state_t;

    typedef struct packed {
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] u;
    } bcd_t;

    // queue handshake between front and back
    typedef struct packed {
        logic  valid;
        kind_t kind;
    } q_head_t;

endpackage

`default_nettype wire

// ----- rtl/cpds_front.sv -----
// request classifier holding the session state
`default_nettype none

module cpds_front
    import cpds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] length,
    input  wire logic        q_full,
    output logic             push,
    output kind_t            push_kind
);

    logic session_open_reg;
    logic session_open_next;
    logic session_served_reg;
    logic session_served_next;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        session_open_next   = session_open_reg;
        session_served_next = session_served_reg;
        push_kind           = KIND_ACK;
        unique case (op)
            OP_OPEN:
            begin
                if (session_open_reg)
                begin
                    push_kind = KIND_BUSY;
                end
                else
                begin
                    session_open_next   = 1'b1;
                    session_served_next = 1'b0;
                end
            end
            OP_RELEASE:
            begin
                session_open_next = 1'b0;
            end
            OP_READ:
            begin
                if (session_served_reg || (length <= 16'd1))
                begin
                    push_kind = KIND_EOD;
                end
                else
                begin
                    push_kind           = KIND_SERVE;
                    session_served_next = 1'b1;
                end
            end
            default:
            begin
                push_kind = KIND_ACK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_open_reg   <= 1'b0;
            session_served_reg <= 1'b0;
        end
        else if (push)
        begin
            session_open_reg   <= session_open_next;
            session_served_reg <= session_served_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cpds_queue.sv -----
// short command queue between front and back
`default_nettype none

module cpds_queue
    import cpds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire kind_t push_kind,
    output logic       full,
    input  wire logic  pop,
    output q_head_t    head
);

    kind_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic                   do_pop;

    assign full       = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.kind  = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cpds_back.sv -----
// result builder and trial division search for the next prime
`default_nettype none

module cpds_back
    import cpds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire q_head_t     head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [1:0]       count,
    output logic [6:0]       char_hundreds,
    output logic [6:0]       char_tens,
    output logic [6:0]       char_units,
    output logic [PRIME_W-1:0] prime_value
);

    back_state_t state_reg, state_next;

    logic [PRIME_W-1:0]   cur_reg, cur_next;
    bcd_t                 cur_bcd_reg, cur_bcd_next;
    logic [PRIME_W-1:0]   cand_reg, cand_next;
    bcd_t                 cand_bcd_reg, cand_bcd_next;
    logic [DIV_W-1:0]     div_reg, div_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [1:0]           count_reg, count_next;
    logic [6:0]           ch_reg, ch_next;
    logic [6:0]           ct_reg, ct_next;
    logic [6:0]           cu_reg, cu_next;
    logic [PRIME_W-1:0]   pv_reg, pv_next;

    logic                 out_free;
    logic                 take;
    logic                 over_limit;
    logic                 root_passed;
    logic [2*DIV_W-1:0]   div_sq;
    logic [REM_W:0]       rem_shift;
    logic [REM_W-1:0]     rem_step;

    function automatic bcd_t bcd_add2(input bcd_t b);
        bcd_t r;
        r = b;
        if (b.u >= 4'd8)
        begin
            r.u = b.u - 4'd8;
            if (b.t == 4'd9)
            begin
                r.t = 4'd0;
                r.h = b.h + 4'd1;
            end
            else
            begin
                r.t = b.t + 4'd1;
            end
        end
        else
        begin
            r.u = b.u + 4'd2;
        end
        return r;
    endfunction

    assign out_free    = !out_valid_reg || out_ready;
    assign take        = (state_reg == ST_IDLE) && head.valid && out_free;
    assign pop         = take;
    assign over_limit  = ({1'b0, cand_reg} > (PRIME_W + 1)'(UPPER_LIMIT));
    assign div_sq      = div_reg * div_reg;
    assign root_passed = (div_sq > (2*DIV_W)'(cand_reg));
    // one restoring remainder step per cycle, msb first
    assign rem_shift   = {rem_reg, cand_reg[bit_reg]};
    assign rem_step    = (rem_shift >= (REM_W + 1)'(div_reg))
                         ? REM_W'(rem_shift - (REM_W + 1)'(div_reg))
                         : REM_W'(rem_shift);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (head.kind == KIND_SERVE) && (cur_reg >= PRIME_W'(3)))
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (over_limit || root_passed)
                    state_next = ST_IDLE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (bit_reg == '0)
                    state_next = ST_TEST;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result register
    always_comb
    begin
        cur_next       = cur_reg;
        cur_bcd_next   = cur_bcd_reg;
        cand_next      = cand_reg;
        cand_bcd_next  = cand_bcd_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        count_next     = count_reg;
        ch_next        = ch_reg;
        ct_next        = ct_reg;
        cu_next        = cu_reg;
        pv_next        = pv_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    count_next     = COUNT_NONE;
                    ch_next        = '0;
                    ct_next        = '0;
                    cu_next        = '0;
                    pv_next        = '0;
                    unique case (head.kind)
                        KIND_BUSY:
                        begin
                            status_next = STATUS_BUSY;
                        end
                        KIND_EOD:
                        begin
                            status_next = STATUS_EOD;
                        end
                        KIND_SERVE:
                        begin
                            count_next = COUNT_SERVED;
                            ch_next    = (cur_bcd_reg.h == 4'd0) ? ASCII_SPACE
                                         : (ASCII_ZERO + {3'b000, cur_bcd_reg.h});
                            ct_next    = ((cur_bcd_reg.h == 4'd0) && (cur_bcd_reg.t == 4'd0))
                                         ? ASCII_SPACE
                                         : (ASCII_ZERO + {3'b000, cur_bcd_reg.t});
                            cu_next    = ASCII_ZERO + {3'b000, cur_bcd_reg.u};
                            pv_next    = cur_reg;
                            if (cur_reg < PRIME_W'(3))
                            begin
                                cur_next     = PRIME_W'(3);
                                cur_bcd_next = '{h: 4'd0, t: 4'd0, u: 4'd3};
                            end
                            else
                            begin
                                cand_next     = cur_reg + PRIME_W'(2);
                                cand_bcd_next = bcd_add2(cur_bcd_reg);
                                div_next      = DIV_W'(3);
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_TEST:
            begin
                if (over_limit)
                begin
                    cur_next     = PRIME_W'(2);
                    cur_bcd_next = '{h: 4'd0, t: 4'd0, u: 4'd2};
                end
                else if (root_passed)
                begin
                    cur_next     = cand_reg;
                    cur_bcd_next = cand_bcd_reg;
                end
                else
                begin
                    rem_next = '0;
                    bit_next = BIT_IDX_W'(PRIME_W - 1);
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        // divisor found, move on to the next odd candidate
                        cand_next     = cand_reg + PRIME_W'(2);
                        cand_bcd_next = bcd_add2(cand_bcd_reg);
                        div_next      = DIV_W'(3);
                    end
                    else
                    begin
                        div_next = div_reg + DIV_W'(2);
                    end
                end
            end
            default:
            begin
                rem_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= PRIME_W'(2);
            cur_bcd_reg   <= '{h: 4'd0, t: 4'd0, u: 4'd2};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            cur_bcd_reg   <= cur_bcd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        cand_bcd_reg <= cand_bcd_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
        ch_reg       <= ch_next;
        ct_reg       <= ct_next;
        cu_reg       <= cu_next;
        pv_reg       <= pv_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign count         = count_reg;
    assign char_hundreds = ch_reg;
    assign char_tens     = ct_reg;
    assign char_units    = cu_reg;
    assign prime_value   = pv_reg;

`ifndef SYNTHESIS
    a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg[0] && (div_reg >= DIV_W'(3))))
        else $error("trial divisor not odd or below three");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < div_reg))
        else $error("partial remainder not below divisor");

    a_bcd_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
        (cur_reg == PRIME_W'(cur_bcd_reg.h * 100 + cur_bcd_reg.t * 10 + cur_bcd_reg.u)))
        else $error("decimal copy of current prime out of step");

    a_hold_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pop)
        else $error("queue popped during prime search");
`endif

endmodule

`default_nettype wire

// ----- rtl/cyclic_prime_digit_source.sv -----
// Cyclic prime digit source: hands out the primes up to 999 in order as three right-aligned
// ASCII characters, one per served read, with open/release session handling. Every beat has
// its result valid in the cycle after it is taken when the back end is idle and its output
// register is free, and the front keeps taking beats into a two-entry queue meanwhile. A served
// read returns its characters just as quickly, but then the back end searches for the next
// prime by serial trial division: per odd candidate a divisor test step, then a bit-serial
// remainder per odd divisor up to the square root (no search after 2, where 3 follows
// directly), and later beats wait in the queue until the search ends.
`default_nettype none

module cyclic_prime_digit_source
    import cpds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [15:0]        length,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [1:0]              count,
    output logic [6:0]              char_hundreds,
    output logic [6:0]              char_tens,
    output logic [6:0]              char_units,
    output logic [PRIME_W-1:0]      prime_value
);

    logic    q_full;
    logic    push;
    kind_t   push_kind;
    logic    pop;
    q_head_t head;

    cpds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .length    (length),
        .q_full    (q_full),
        .push      (push),
        .push_kind (push_kind)
    );

    cpds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_kind (push_kind),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    cpds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .count         (count),
        .char_hundreds (char_hundreds),
        .char_tens     (char_tens),
        .char_units    (char_units),
        .prime_value   (prime_value)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the cyclic prime digit source: directed table, then random sessions
`timescale 1ns / 1ps

module tb_top
    import cpds_pkg::*;
();

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         IDLE_PCT   = 22;
    localparam int         RAND_ITEMS = 280;
    localparam int         HOLD_LEN   = 300;
    localparam int         DRAIN_WAIT = 2500;
    localparam longint     CYCLE_CAP  = 64'd10_000_000;
    localparam int         DIR_ROWS   = 20;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         count;
        logic [6:0]         ch;
        logic [6:0]         ct;
        logic [6:0]         cu;
        logic [PRIME_W-1:0] pv;
    } reply_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] len;
        logic        typed;
        reply_t      reply;
    } row_t;

    localparam reply_t NO_REPLY = '0;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          op;
    logic [15:0]         length;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic [1:0]          count;
    logic [6:0]          char_hundreds;
    logic [6:0]          char_tens;
    logic [6:0]          char_units;
    logic [PRIME_W-1:0]  prime_value;

    // predictor state
    logic [PRIME_W-1:0]  next_prime_out;
    logic                served_mark;
    logic                session_up;

    reply_t              pending_replies [$];
    int                  errors = 0;
    longint              cycles = 0;
    bit                  calm;
    bit                  hold_req;
    bit                  hold_done = 1'b0;
    int                  hold_left = 0;

    row_t dir_rows [0:DIR_ROWS-1] = '{
        {OP_READ,    16'd2,     1'b1, STATUS_OK, COUNT_SERVED, ASCII_SPACE, ASCII_SPACE,
            7'h32, 10'd2},
        {OP_READ,    16'hFFFF,  1'b1, STATUS_EOD, COUNT_NONE, 7'd0, 7'd0, 7'd0, 10'd0},
        {OP_RELEASE, 16'd0,     1'b1, NO_REPLY},
        {OP_OPEN,    16'd0,     1'b1, NO_REPLY},
        {OP_OPEN,    16'd0,     1'b1, STATUS_BUSY, COUNT_NONE, 7'd0, 7'd0, 7'd0, 10'd0},
        {OP_READ,    16'd0,     1'b1, STATUS_EOD, COUNT_NONE, 7'd0, 7'd0, 7'd0, 10'd0},
        {OP_READ,    16'd1,     1'b1, STATUS_EOD, COUNT_NONE, 7'd0, 7'd0, 7'd0, 10'd0},
        {OP_READ,    16'hFFFF,  1'b1, STATUS_OK, COUNT_SERVED, ASCII_SPACE, ASCII_SPACE,
            7'h33, 10'd3},
        {OP_READ,    16'd2,     1'b1, STATUS_EOD, COUNT_NONE, 7'd0, 7'd0, 7'd0, 10'd0},
        {OP_SPARE,   16'hFFFF,  1'b1, NO_REPLY},
        {OP_RELEASE, 16'd0,     1'b1, NO_REPLY},
        {OP_RELEASE, 16'hFFFF,  1'b1, NO_REPLY},
        {OP_OPEN,    16'hFFFF,  1'b1, NO_REPLY},
        {OP_READ,    16'h8000,  1'b0, NO_REPLY},
        {OP_RELEASE, 16'h5555,  1'b0, NO_REPLY},
        {OP_OPEN,    16'h0000,  1'b0, NO_REPLY},
        {OP_READ,    16'h5555,  1'b0, NO_REPLY},
        {OP_READ,    16'hAAAA,  1'b1, STATUS_EOD, COUNT_NONE, 7'd0, 7'd0, 7'd0, 10'd0},
        {OP_SPARE,   16'd0,     1'b1, NO_REPLY},
        {OP_RELEASE, 16'hAAAA,  1'b0, NO_REPLY}
    };

    cyclic_prime_digit_source uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .length        (length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .count         (count),
        .char_hundreds (char_hundreds),
        .char_tens     (char_tens),
        .char_units    (char_units),
        .prime_value   (prime_value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [PRIME_W-1:0] prime_after(input logic [PRIME_W-1:0] p);
        int  c;
        int  d;
        bit  composite;
        if (p < 3)
            return PRIME_W'(3);
        for (c = (p | 1) + 2; c <= UPPER_LIMIT; c += 2)
        begin
            composite = 1'b0;
            for (d = 3; d * d <= c; d += 2)
            begin
                if (c % d == 0)
                    composite = 1'b1;
            end
            if (!composite)
                return PRIME_W'(c);
        end
        return PRIME_W'(2);
    endfunction

    // advances the predictor by one request and returns the reply it gives
    function automatic reply_t next_reply(input logic [1:0] o, input logic [15:0] l);
        reply_t r;
        int     p;
        r = NO_REPLY;
        r.status = STATUS_OK;
        r.count  = COUNT_NONE;
        case (o)
            OP_OPEN:
            begin
                if (session_up)
                    r.status = STATUS_BUSY;
                else
                begin
                    session_up  = 1'b1;
                    served_mark = 1'b0;
                end
            end
            OP_RELEASE:
                session_up = 1'b0;
            OP_READ:
            begin
                if (served_mark || l <= 16'd1)
                    r.status = STATUS_EOD;
                else
                begin
                    p       = int'(next_prime_out);
                    r.ch    = (p < 100) ? ASCII_SPACE : ASCII_ZERO + 7'((p / 100) % 10);
                    r.ct    = (p < 10) ? ASCII_SPACE : ASCII_ZERO + 7'((p / 10) % 10);
                    r.cu    = ASCII_ZERO + 7'(p % 10);
                    r.pv    = next_prime_out;
                    r.count = COUNT_SERVED;
                    served_mark    = 1'b1;
                    next_prime_out = prime_after(next_prime_out);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offers one beat and records its reply once accepted
    task automatic send_beat(input logic [1:0] o, input logic [15:0] l,
                             input bit typed, input reply_t typed_reply);
        reply_t predicted;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        length   <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = next_reply(o, l);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    function automatic logic [15:0] any_length();
        if ($urandom_range(0, 99) < 20)
            return 16'($urandom_range(0, 2));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, got status %0d prime %0d",
                         $time, status, prime_value);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                compare_field("status", want.status, status);
                compare_field("count", want.count, count);
                compare_field("char_hundreds", want.ch, char_hundreds);
                compare_field("char_tens", want.ct, char_tens);
                compare_field("char_units", want.cu, char_units);
                compare_field("prime_value", want.pv, prime_value);
            end
        end
    end

    // receiver side: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("%0t: timeout with %0d replies outstanding", $time,
                     pending_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int       sent;
        int       i;
        int       pick;
        logic [1:0] o;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_OPEN;
        length         = 16'd0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        next_prime_out = 10'd2;
        served_mark    = 1'b0;
        session_up     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].op, dir_rows[i].len, dir_rows[i].typed, dir_rows[i].reply);

        // mostly whole sessions so most reads are served
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            calm     = (sent >= 100 && sent < 160);
            hold_req = (sent >= 40);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_beat(OP_OPEN, 16'($urandom_range(0, 65535)), 1'b0, NO_REPLY);
                send_beat(OP_READ, 16'($urandom_range(2, 65535)), 1'b0, NO_REPLY);
                sent += 2;
                if ($urandom_range(0, 99) < 30)
                begin
                    send_beat(OP_READ, any_length(), 1'b0, NO_REPLY);
                    sent++;
                end
                if ($urandom_range(0, 99) < 20)
                begin
                    send_beat(OP_SPARE, 16'($urandom_range(0, 65535)), 1'b0, NO_REPLY);
                    sent++;
                end
                send_beat(OP_RELEASE, 16'($urandom_range(0, 65535)), 1'b0, NO_REPLY);
                sent++;
            end
            else
            begin
                o = 2'($urandom_range(0, 3));
                send_beat(o, any_length(), 1'b0, NO_REPLY);
                sent++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0 && pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- cyclic_prime_digit_source.f -----
rtl/cpds_pkg.sv
rtl/cpds_front.sv
rtl/cpds_queue.sv
rtl/cpds_back.sv
rtl/cyclic_prime_digit_source.sv
tb/tb_top.sv
